// ===== hw/rtl/nllfr_pkg.sv =====
`timescale 1ns / 1ps

package nllfr_pkg;

    localparam int LOSS_W    = 48;
    localparam int WSUM_W    = 36;
    localparam int WEIGHT_W  = 16;
    localparam int LOGIT_W   = 24;
    localparam int PROD_W    = LOGIT_W + WEIGHT_W + 1;
    localparam int RND_W     = PROD_W + 1;
    localparam int FRAC_DROP = 14;
    localparam int TERM_W    = RND_W - FRAC_DROP;

    // Mean numerator is |loss_sum| * 2^14 plus half the weight total.
    localparam int DIV_NUM_W = LOSS_W + FRAC_DROP;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd16384;
    localparam logic signed [LOSS_W-1:0] LOSS_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [LOSS_W-1:0] LOSS_MIN = 48'sh8000_0000_0000;
    localparam logic [WSUM_W-1:0] WSUM_MAX = 36'hF_FFFF_FFFF;

    localparam logic [1:0] RED_NONE = 2'd0;
    localparam logic [1:0] RED_MEAN = 2'd1;
    localparam logic [1:0] RED_SUM  = 2'd2;

    localparam logic [1:0] REG_REDUCTION   = 2'd0;
    localparam logic [1:0] REG_IGNORE      = 2'd1;
    localparam logic [1:0] REG_USE_WEIGHTS = 2'd2;
    localparam logic [1:0] REG_CLASS_COUNT = 2'd3;

    localparam logic MODE_WEIGHT = 1'b0;
    localparam logic MODE_PIXEL  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_ZERO_WT = 2'd3;

    localparam logic [1:0]         RESET_REDUCTION   = RED_MEAN;
    localparam logic signed [15:0] RESET_IGNORE      = -16'sd100;
    localparam logic               RESET_USE_WEIGHTS = 1'b0;
    localparam logic [10:0]        RESET_CLASS_COUNT = 11'd1024;

endpackage

// ===== hw/rtl/nllfr_weight_mem.sv =====
`timescale 1ns / 1ps

module nllfr_weight_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic [nllfr_pkg::WEIGHT_W-1:0]    wr_data,
    input  logic                              rd_en,
    input  logic [AW-1:0]                     rd_addr,
    output logic [nllfr_pkg::WEIGHT_W-1:0]    rd_data
);

    logic [nllfr_pkg::WEIGHT_W-1:0] ram_reg [DEPTH];
    logic [nllfr_pkg::WEIGHT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/nllfr_div.sv =====
`timescale 1ns / 1ps

module nllfr_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [nllfr_pkg::DIV_NUM_W-1:0]    numer,
    input  logic [nllfr_pkg::WSUM_W-1:0]       denom,
    output logic                               done,
    output logic [nllfr_pkg::DIV_NUM_W-1:0]    quot
);

    logic                              run_reg, run_next;
    logic                              done_reg, done_next;
    logic [nllfr_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [nllfr_pkg::WSUM_W-1:0]      rem_reg, rem_next;
    logic [nllfr_pkg::WSUM_W-1:0]      den_reg, den_next;
    logic [nllfr_pkg::DIV_NUM_W-1:0]   quot_reg, quot_next;
    logic [nllfr_pkg::WSUM_W:0]        trial;
    logic [nllfr_pkg::WSUM_W:0]        diff;

    // Restoring division: the numerator shifts out of quot_reg as quotient bits shift in.
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        trial     = {rem_reg, quot_reg[nllfr_pkg::DIV_NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = nllfr_pkg::DIV_CNT_W'(nllfr_pkg::DIV_NUM_W - 1);
            rem_next  = '0;
            den_next  = denom;
            quot_next = numer;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = diff[nllfr_pkg::WSUM_W-1:0];
                quot_next = {quot_reg[nllfr_pkg::DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[nllfr_pkg::WSUM_W-1:0];
                quot_next = {quot_reg[nllfr_pkg::DIV_NUM_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hw/rtl/nll_loss_forward_reduce_unit.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake             | Payload
// config   | cfg_write             | cfg_index, cfg_data
// input    | in_valid / in_ready   | mode, weight_address, weight_value, target_class, logit,
//          |                       | last_pixel
// output   | out_valid / out_ready | loss_value, weight_total, is_total, status
//
// A weight item needs no further work once it is accepted. A pixel walks through table read,
// multiply, round and accumulate; a per-pixel result adds an emit step, a sum total adds total
// and emit steps, and a mean total also waits on the 62-step bit-serial divider.
// The weight table has no reset; sums, error flag and registers reset asynchronously.
// A result waiting on out_ready holds the block only when the next result is ready to load.

module nll_loss_forward_reduce_unit #(
    parameter int MAX_CLASSES = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic [9:0]          weight_address,
    input  logic [15:0]         weight_value,
    input  logic signed [15:0]  target_class,
    input  logic signed [23:0]  logit,
    input  logic                last_pixel,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [47:0]  loss_value,
    output logic [35:0]         weight_total,
    output logic                is_total,
    output logic [1:0]          status
);

    localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RND,
        S_ACC,
        S_TOT,
        S_DIV,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]         reduction_reg;
    logic signed [15:0] ignore_reg;
    logic               use_weights_reg;
    logic [10:0]        class_count_reg;

    logic signed [nllfr_pkg::LOGIT_W-1:0]  logit_reg, logit_next;
    logic                                  ignored_reg, ignored_next;
    logic                                  tvalid_reg, tvalid_next;
    logic                                  last_reg, last_next;
    logic [nllfr_pkg::WEIGHT_W-1:0]        w_reg, w_next;
    logic signed [nllfr_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic signed [nllfr_pkg::TERM_W-1:0]   term_reg, term_next;

    logic signed [nllfr_pkg::LOSS_W-1:0]   loss_sum_reg, loss_sum_next;
    logic [nllfr_pkg::WSUM_W-1:0]          wsum_reg, wsum_next;
    logic                                  err_reg, err_next;

    logic signed [nllfr_pkg::LOSS_W-1:0]   res_loss_reg, res_loss_next;
    logic [nllfr_pkg::WSUM_W-1:0]          res_wt_reg, res_wt_next;
    logic                                  res_total_reg, res_total_next;
    logic [1:0]                            res_status_reg, res_status_next;
    logic                                  res_neg_reg, res_neg_next;

    logic                                  out_valid_reg, out_valid_next;
    logic signed [nllfr_pkg::LOSS_W-1:0]   loss_value_reg, loss_value_next;
    logic [nllfr_pkg::WSUM_W-1:0]          weight_total_reg, weight_total_next;
    logic                                  is_total_reg, is_total_next;
    logic [1:0]                            status_reg, status_next;

    logic                                  in_accept;
    logic                                  tgt_ignored;
    logic                                  tgt_valid;
    logic                                  wr_in_range;
    logic                                  mem_wr_en;
    logic                                  mem_rd_en;
    logic [nllfr_pkg::WEIGHT_W-1:0]        mem_rdata;
    logic [nllfr_pkg::WEIGHT_W-1:0]        weight_sel;
    logic signed [nllfr_pkg::RND_W-1:0]    rnd;
    logic signed [nllfr_pkg::LOSS_W:0]     lsum_wide;
    logic [nllfr_pkg::WSUM_W:0]            wsum_wide;
    logic [nllfr_pkg::LOSS_W-1:0]          loss_mag;
    logic [nllfr_pkg::DIV_NUM_W-1:0]       div_numer;
    logic                                  div_start;
    logic                                  div_done;
    logic [nllfr_pkg::DIV_NUM_W-1:0]       div_quot;
    logic                                  quot_big;
    logic [nllfr_pkg::LOSS_W-1:0]          quot_low;
    logic signed [nllfr_pkg::LOSS_W-1:0]   mean_sat;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;

    assign tgt_ignored = (target_class == ignore_reg);
    assign tgt_valid   = !target_class[15]
                         && ({1'b0, target_class[14:0]} < {5'd0, class_count_reg})
                         && ({17'd0, target_class[14:0]} < 32'(MAX_CLASSES));
    assign wr_in_range = ({22'd0, weight_address} < 32'(MAX_CLASSES));
    assign mem_wr_en   = in_accept && (mode == nllfr_pkg::MODE_WEIGHT) && wr_in_range;
    assign mem_rd_en   = in_accept && (mode == nllfr_pkg::MODE_PIXEL);

    nllfr_weight_mem #(
        .DEPTH (MAX_CLASSES),
        .AW    (AW)
    ) u_weight_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (AW'(weight_address)),
        .wr_data (weight_value),
        .rd_en   (mem_rd_en),
        .rd_addr (AW'($unsigned(target_class))),
        .rd_data (mem_rdata)
    );

    assign weight_sel = (tvalid_reg && use_weights_reg) ? mem_rdata : nllfr_pkg::WEIGHT_ONE;

    // Negated Q.30 product rounded to Q.16, ties toward plus infinity.
    assign rnd = -(nllfr_pkg::RND_W'(prod_reg)) + nllfr_pkg::RND_W'(8192);

    assign lsum_wide = {loss_sum_reg[nllfr_pkg::LOSS_W-1], loss_sum_reg}
                       + (nllfr_pkg::LOSS_W + 1)'(term_reg);
    assign wsum_wide = {1'b0, wsum_reg} + (nllfr_pkg::WSUM_W + 1)'(w_reg);

    assign loss_mag  = loss_sum_reg[nllfr_pkg::LOSS_W-1] ? (~loss_sum_reg + 1'b1)
                                                          : loss_sum_reg;
    assign div_numer = {loss_mag, {nllfr_pkg::FRAC_DROP{1'b0}}}
                       + nllfr_pkg::DIV_NUM_W'(wsum_reg[nllfr_pkg::WSUM_W-1:1]);
    assign div_start = (state_reg == S_TOT) && (reduction_reg == nllfr_pkg::RED_MEAN)
                       && (wsum_reg != '0);

    nllfr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (wsum_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign quot_big = |div_quot[nllfr_pkg::DIV_NUM_W-1:nllfr_pkg::LOSS_W-1];
    assign quot_low = div_quot[nllfr_pkg::LOSS_W-1:0];
    assign mean_sat = res_neg_reg ? (quot_big ? nllfr_pkg::LOSS_MIN : -$signed(quot_low))
                                  : (quot_big ? nllfr_pkg::LOSS_MAX : $signed(quot_low));

    always_comb
    begin
        state_next        = state_reg;
        logit_next        = logit_reg;
        ignored_next      = ignored_reg;
        tvalid_next       = tvalid_reg;
        last_next         = last_reg;
        w_next            = w_reg;
        prod_next         = prod_reg;
        term_next         = term_reg;
        loss_sum_next     = loss_sum_reg;
        wsum_next         = wsum_reg;
        err_next          = err_reg;
        res_loss_next     = res_loss_reg;
        res_wt_next       = res_wt_reg;
        res_total_next    = res_total_reg;
        res_status_next   = res_status_reg;
        res_neg_next      = res_neg_reg;
        out_valid_next    = out_valid_reg;
        loss_value_next   = loss_value_reg;
        weight_total_next = weight_total_reg;
        is_total_next     = is_total_reg;
        status_next       = status_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (mode == nllfr_pkg::MODE_PIXEL))
                begin
                    logit_next   = logit;
                    ignored_next = tgt_ignored;
                    tvalid_next  = tgt_valid;
                    last_next    = last_pixel;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                w_next     = weight_sel;
                prod_next  = logit_reg * $signed({1'b0, weight_sel});
                state_next = S_RND;
            end
            S_RND:
            begin
                term_next  = rnd[nllfr_pkg::RND_W-1:nllfr_pkg::FRAC_DROP];
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (reduction_reg == nllfr_pkg::RED_NONE)
                begin
                    res_wt_next    = '0;
                    res_total_next = 1'b0;
                    if (ignored_reg)
                    begin
                        res_loss_next   = '0;
                        res_status_next = nllfr_pkg::ST_IGNORED;
                    end
                    else if (!tvalid_reg)
                    begin
                        res_loss_next   = '0;
                        res_status_next = nllfr_pkg::ST_RANGE;
                    end
                    else
                    begin
                        res_loss_next   = nllfr_pkg::LOSS_W'(term_reg);
                        res_status_next = nllfr_pkg::ST_OK;
                    end
                    state_next = S_EMIT;
                end
                else
                begin
                    if (!ignored_reg)
                    begin
                        if (!tvalid_reg)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            if (lsum_wide[nllfr_pkg::LOSS_W] != lsum_wide[nllfr_pkg::LOSS_W-1])
                            begin
                                loss_sum_next = lsum_wide[nllfr_pkg::LOSS_W] ? nllfr_pkg::LOSS_MIN
                                                                              : nllfr_pkg::LOSS_MAX;
                            end
                            else
                            begin
                                loss_sum_next = lsum_wide[nllfr_pkg::LOSS_W-1:0];
                            end
                            wsum_next = wsum_wide[nllfr_pkg::WSUM_W] ? nllfr_pkg::WSUM_MAX
                                                                     : wsum_wide[nllfr_pkg::WSUM_W-1:0];
                        end
                    end
                    state_next = last_reg ? S_TOT : S_IDLE;
                end
            end
            S_TOT:
            begin
                res_wt_next     = wsum_reg;
                res_total_next  = 1'b1;
                res_status_next = err_reg ? nllfr_pkg::ST_RANGE : nllfr_pkg::ST_OK;
                res_neg_next    = loss_sum_reg[nllfr_pkg::LOSS_W-1];
                res_loss_next   = loss_sum_reg;
                state_next      = S_EMIT;
                if (reduction_reg == nllfr_pkg::RED_MEAN)
                begin
                    if (wsum_reg == '0)
                    begin
                        res_loss_next   = '0;
                        res_status_next = err_reg ? nllfr_pkg::ST_RANGE : nllfr_pkg::ST_ZERO_WT;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
                // The divider has latched its operands, so the set can start over now.
                loss_sum_next = '0;
                wsum_next     = '0;
                err_next      = 1'b0;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_loss_next = mean_sat;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    loss_value_next   = res_loss_reg;
                    weight_total_next = res_wt_reg;
                    is_total_next     = res_total_reg;
                    status_next       = res_status_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            reduction_reg    <= nllfr_pkg::RESET_REDUCTION;
            ignore_reg       <= nllfr_pkg::RESET_IGNORE;
            use_weights_reg  <= nllfr_pkg::RESET_USE_WEIGHTS;
            class_count_reg  <= nllfr_pkg::RESET_CLASS_COUNT;
            logit_reg        <= '0;
            ignored_reg      <= 1'b0;
            tvalid_reg       <= 1'b0;
            last_reg         <= 1'b0;
            w_reg            <= '0;
            prod_reg         <= '0;
            term_reg         <= '0;
            loss_sum_reg     <= '0;
            wsum_reg         <= '0;
            err_reg          <= 1'b0;
            res_loss_reg     <= '0;
            res_wt_reg       <= '0;
            res_total_reg    <= 1'b0;
            res_status_reg   <= nllfr_pkg::ST_OK;
            res_neg_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            loss_value_reg   <= '0;
            weight_total_reg <= '0;
            is_total_reg     <= 1'b0;
            status_reg       <= nllfr_pkg::ST_OK;
        end
        else
        begin
            state_reg        <= state_next;
            logit_reg        <= logit_next;
            ignored_reg      <= ignored_next;
            tvalid_reg       <= tvalid_next;
            last_reg         <= last_next;
            w_reg            <= w_next;
            prod_reg         <= prod_next;
            term_reg         <= term_next;
            loss_sum_reg     <= loss_sum_next;
            wsum_reg         <= wsum_next;
            err_reg          <= err_next;
            res_loss_reg     <= res_loss_next;
            res_wt_reg       <= res_wt_next;
            res_total_reg    <= res_total_next;
            res_status_reg   <= res_status_next;
            res_neg_reg      <= res_neg_next;
            out_valid_reg    <= out_valid_next;
            loss_value_reg   <= loss_value_next;
            weight_total_reg <= weight_total_next;
            is_total_reg     <= is_total_next;
            status_reg       <= status_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    nllfr_pkg::REG_REDUCTION:   reduction_reg   <= cfg_data[1:0];
                    nllfr_pkg::REG_IGNORE:      ignore_reg      <= cfg_data;
                    nllfr_pkg::REG_USE_WEIGHTS: use_weights_reg <= cfg_data[0];
                    nllfr_pkg::REG_CLASS_COUNT: class_count_reg <= cfg_data[10:0];
                    default:                    reduction_reg   <= reduction_reg;
                endcase
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign loss_value   = loss_value_reg;
    assign weight_total = weight_total_reg;
    assign is_total     = is_total_reg;
    assign status       = status_reg;

endmodule

// ===== hw/rtl/nllfr_checker.sv =====
`timescale 1ns / 1ps

module nllfr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                mode,
    input logic                out_valid,
    input logic                out_ready,
    input logic signed [47:0]  loss_value,
    input logic [35:0]         weight_total,
    input logic                is_total,
    input logic [1:0]          status
);

    // A pixel item keeps the block busy after it is accepted, so no item can follow at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (mode == nllfr_pkg::MODE_PIXEL) |=> !in_ready)
        else $error("pixel item accepted without a busy cycle after it");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(loss_value) && $stable(status))
        else $error("stalled result item changed or dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_total |-> weight_total == '0)
        else $error("per-pixel result carries a weight total");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == nllfr_pkg::ST_ZERO_WT)
            |-> is_total && (loss_value == '0) && (weight_total == '0))
        else $error("zero-weight mean status on a malformed result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == nllfr_pkg::ST_IGNORED) |-> !is_total && (loss_value == '0))
        else $error("ignored status on a total or with nonzero loss");

endmodule

bind nll_loss_forward_reduce_unit nllfr_checker u_nllfr_checker (.*);

// ===== test/nll_loss_checker.sv =====
`timescale 1ns / 1ps

module nll_loss_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               mode,
    input  logic [9:0]         weight_address,
    input  logic [15:0]        weight_value,
    input  logic signed [15:0] target_class,
    input  logic signed [23:0] logit,
    input  logic               last_pixel,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [47:0] loss_value,
    input  logic [35:0]        weight_total,
    input  logic               is_total,
    input  logic [1:0]         status,
    output int                 mismatch_count,
    output int                 pending,
    output int                 pixel_results,
    output int                 set_totals
);
    import nllfr_pkg::*;

    localparam int     TABLE_DEPTH = 1024;
    localparam int     PRINT_CAP   = 30;
    localparam longint LOSS_HI     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint LOSS_LO     = -LOSS_HI - 1;

    typedef struct packed {
        logic signed [47:0] loss;
        logic [35:0]        wsum;
        logic               total;
        logic [1:0]         st;
    } loss_result_t;

    loss_result_t expected_losses[$];
    loss_result_t want;

    logic [15:0]        weight_table [TABLE_DEPTH];
    logic [1:0]         red_sel;
    logic signed [15:0] skip_class;
    logic               weights_on;
    logic [10:0]        class_limit;

    longint      loss_acc;
    logic [35:0] weight_acc;
    logic        range_err;

    int errors = 0;
    int pixel_count = 0;
    int total_count = 0;

    assign mismatch_count = errors;
    assign pixel_results  = pixel_count;
    assign set_totals     = total_count;

    task automatic report(input string what);
        if (errors < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    // Q.30 product taken to Q.16, rounding half toward plus infinity.
    function automatic longint rounded_term(input logic signed [23:0] lg, input logic [15:0] w);
        longint p;
        p = -longint'(lg) * longint'(w);
        return (p + 64'sd8192) >>> 14;
    endfunction

    function automatic longint clamp_loss(input longint v);
        if (v > LOSS_HI)
            return LOSS_HI;
        if (v < LOSS_LO)
            return LOSS_LO;
        return v;
    endfunction

    function automatic bit predict_pixel(input logic signed [15:0] tgt,
                                         input logic signed [23:0] lg,
                                         input logic lastp,
                                         output loss_result_t r);
        bit          skip;
        bit          in_range;
        logic [15:0] w;
        logic [36:0] wide;
        logic [63:0] mag;
        logic [63:0] q;
        skip     = (tgt == skip_class);
        in_range = (tgt >= 0) && (int'(tgt) < int'(class_limit)) && (int'(tgt) < TABLE_DEPTH);
        w        = WEIGHT_ONE;
        if (in_range && weights_on)
            w = weight_table[tgt[9:0]];
        r = '0;

        if (red_sel == RED_NONE)
        begin
            if (skip)
                r.st = ST_IGNORED;
            else if (!in_range)
                r.st = ST_RANGE;
            else
                r.loss = 48'(rounded_term(lg, w));
            return 1'b1;
        end

        if (!skip)
        begin
            if (!in_range)
                range_err = 1'b1;
            else
            begin
                loss_acc   = clamp_loss(loss_acc + rounded_term(lg, w));
                wide       = {1'b0, weight_acc} + 37'(w);
                weight_acc = wide[36] ? WSUM_MAX : wide[35:0];
            end
        end

        if (!lastp)
            return 1'b0;

        r.total = 1'b1;
        r.wsum  = weight_acc;
        r.st    = range_err ? ST_RANGE : ST_OK;
        r.loss  = loss_acc[47:0];
        if (red_sel == RED_MEAN)
        begin
            if (weight_acc == '0)
            begin
                r.loss = '0;
                if (!range_err)
                    r.st = ST_ZERO_WT;
            end
            else
            begin
                // Magnitude is rounded half away from zero, then the sign is put back.
                mag = (loss_acc < 0) ? 64'(-loss_acc) : 64'(loss_acc);
                q   = ((mag << 14) + {29'd0, weight_acc[35:1]}) / {28'd0, weight_acc};
                if (loss_acc < 0)
                    r.loss = (q >= 64'h0000_8000_0000_0000) ? LOSS_MIN : -q[47:0];
                else
                    r.loss = (q > 64'h0000_7FFF_FFFF_FFFF) ? LOSS_MAX : q[47:0];
            end
        end
        loss_acc   = 0;
        weight_acc = '0;
        range_err  = 1'b0;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_losses.delete();
            red_sel     = RESET_REDUCTION;
            skip_class  = RESET_IGNORE;
            weights_on  = RESET_USE_WEIGHTS;
            class_limit = RESET_CLASS_COUNT;
            loss_acc    = 0;
            weight_acc  = '0;
            range_err   = 1'b0;
            pending    <= 0;
        end
        else
        begin
            // Results are checked before this edge's item is predicted, so a stray
            // result can never be matched against an expectation made at the same edge.
            if (out_valid && out_ready)
            begin
                if (expected_losses.size() == 0)
                    report($sformatf("result with nothing expected: loss=%0d total=%0b status=%0d",
                                     loss_value, is_total, status));
                else
                begin
                    want = expected_losses.pop_front();
                    if (loss_value !== want.loss)
                        report($sformatf("loss_value got %0d want %0d", loss_value, want.loss));
                    if (weight_total !== want.wsum)
                        report($sformatf("weight_total got %0d want %0d",
                                         weight_total, want.wsum));
                    if (is_total !== want.total)
                        report($sformatf("is_total got %0b want %0b", is_total, want.total));
                    if (status !== want.st)
                        report($sformatf("status got %0d want %0d", status, want.st));
                    if (want.total)
                        total_count++;
                    else
                        pixel_count++;
                end
            end

            if (in_valid && in_ready)
            begin
                if (mode == MODE_WEIGHT)
                    weight_table[weight_address] = weight_value;
                else if (predict_pixel(target_class, logit, last_pixel, want))
                    expected_losses.push_back(want);
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_REDUCTION:   red_sel     = cfg_data[1:0];
                    REG_IGNORE:      skip_class  = cfg_data;
                    REG_USE_WEIGHTS: weights_on  = cfg_data[0];
                    REG_CLASS_COUNT: class_limit = cfg_data[10:0];
                    default:         ;
                endcase
            end

            pending <= expected_losses.size();
        end
    end

endmodule

// ===== test/tb_nll_loss_forward_reduce_unit.sv =====
`timescale 1ns / 1ps

module tb_nll_loss_forward_reduce_unit;
    import nllfr_pkg::*;

    localparam int         TABLE_DEPTH    = 1024;
    localparam int         PHASES         = 9;
    localparam int         PHASE_ITEMS    = 150;
    localparam int         SETTLE_CYCLES  = 100;
    localparam int         CYCLE_LIMIT    = 1000000;
    // Selector value 3 is not a named mode; the block treats it as a sum.
    localparam logic [1:0] RED_SUM_ALIAS  = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               cfg_write      = 1'b0;
    logic [1:0]         cfg_index      = '0;
    logic [15:0]        cfg_data       = '0;
    logic               in_valid       = 1'b0;
    logic               in_ready;
    logic               mode           = MODE_PIXEL;
    logic [9:0]         weight_address = '0;
    logic [15:0]        weight_value   = '0;
    logic signed [15:0] target_class   = '0;
    logic signed [23:0] logit          = '0;
    logic               last_pixel     = 1'b0;
    logic               out_valid;
    logic               out_ready      = 1'b0;
    logic signed [47:0] loss_value;
    logic [35:0]        weight_total;
    logic               is_total;
    logic [1:0]         status;

    int mismatches;
    int results_outstanding;
    int pixel_results;
    int set_totals;

    int cycle_count  = 0;
    int ready_style  = 0;
    int style_left   = 0;
    int burst_left   = 0;
    int items_sent   = 0;
    int pixels_sent  = 0;
    int weights_sent = 0;
    int settings_run = 1;

    // Host-side copy of the registers and of which table entries hold a weight.
    logic [1:0] cur_reduction = RESET_REDUCTION;
    int         cur_ignore    = -100;
    logic       cur_weights   = RESET_USE_WEIGHTS;
    int         cur_classes   = 1024;
    bit         written [TABLE_DEPTH];
    int         written_list[$];

    always #10 clk = ~clk;

    nll_loss_forward_reduce_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .weight_address (weight_address),
        .weight_value   (weight_value),
        .target_class   (target_class),
        .logit          (logit),
        .last_pixel     (last_pixel),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .loss_value     (loss_value),
        .weight_total   (weight_total),
        .is_total       (is_total),
        .status         (status)
    );

    nll_loss_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .weight_address (weight_address),
        .weight_value   (weight_value),
        .target_class   (target_class),
        .logit          (logit),
        .last_pixel     (last_pixel),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .loss_value     (loss_value),
        .weight_total   (weight_total),
        .is_total       (is_total),
        .status         (status),
        .mismatch_count (mismatches),
        .pending        (results_outstanding),
        .pixel_results  (pixel_results),
        .set_totals     (set_totals)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, results_outstanding);
            $display("Test completed with failures");
            $finish;
        end
    end

    // The receiver switches between always ready, coin flips, sparse ready and periodic stalls.
    always @(posedge clk)
    begin
        if (style_left == 0)
        begin
            ready_style <= $urandom_range(0, 3);
            style_left  <= $urandom_range(16, 256);
        end
        else
            style_left <= style_left - 1;
        case (ready_style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 4) == 0);
            default: out_ready <= ((cycle_count % 8) < 5);
        endcase
    end

    task automatic drive_item(input logic m, input logic [9:0] addr, input logic [15:0] wv,
                              input int tgt, input logic signed [23:0] lg, input logic lastp);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid       <= 1'b1;
        mode           <= m;
        weight_address <= addr;
        weight_value   <= wv;
        target_class   <= 16'(tgt);
        logit          <= lg;
        last_pixel     <= lastp;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic send_pixel(input int tgt, input logic signed [23:0] lg, input logic lastp);
        drive_item(MODE_PIXEL, 10'($urandom()), 16'($urandom()), tgt, lg, lastp);
        pixels_sent++;
    endtask

    task automatic send_weight(input int addr, input logic [15:0] wv);
        drive_item(MODE_WEIGHT, 10'(addr), wv, int'($urandom_range(0, 65535)) - 32768,
                   24'($urandom()), 1'($urandom_range(0, 1)));
        if (!written[addr])
        begin
            written[addr] = 1'b1;
            written_list.push_back(addr);
        end
        weights_sent++;
    endtask

    task automatic wait_for_results(input bit settle);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_outstanding != 0);
        // A pixel with no result may still be in flight after the last result.
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] red, input int ign, input logic uw,
                              input int cc);
        cfg_write <= 1'b1;
        cfg_index <= REG_REDUCTION;
        cfg_data  <= {14'd0, red};
        @(posedge clk);
        cfg_index <= REG_IGNORE;
        cfg_data  <= 16'(ign);
        @(posedge clk);
        cfg_index <= REG_USE_WEIGHTS;
        cfg_data  <= {15'd0, uw};
        @(posedge clk);
        cfg_index <= REG_CLASS_COUNT;
        cfg_data  <= 16'(cc);
        @(posedge clk);
        cfg_write     <= 1'b0;
        cur_reduction = red;
        cur_ignore    = ign;
        cur_weights   = uw;
        cur_classes   = cc;
        settings_run++;
    endtask

    // True when a pixel with this target would look up a table entry never written.
    function automatic bit reads_unwritten(input int t);
        return cur_weights && t >= 0 && t < cur_classes && !written[t];
    endfunction

    function automatic int any_written();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    function automatic int choose_target();
        int                 t;
        int                 pick;
        logic signed [15:0] raw;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            t = cur_ignore;
        else if (pick < 26)
        begin
            case ($urandom_range(0, 2))
                0: t = -1 - int'($urandom_range(0, 32767));
                1: t = cur_classes + int'($urandom_range(0, 32767 - cur_classes));
                default:
                begin
                    raw = 16'($urandom());
                    t   = raw;
                end
            endcase
        end
        else if (cur_weights)
        begin
            t = any_written();
            for (int k = 0; k < 4 && t >= cur_classes; k++)
                t = any_written();
        end
        else
            t = $urandom_range(0, cur_classes - 1);
        if (reads_unwritten(t))
            t = any_written();
        return t;
    endfunction

    function automatic logic signed [23:0] choose_logit();
        logic signed [23:0] v;
        case ($urandom_range(0, 9))
            0:             v = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            1, 2, 3, 4:    v = 24'(int'($urandom_range(0, 600000)) - 300000);
            default:       v = 24'($urandom());
        endcase
        return v;
    endfunction

    function automatic logic [15:0] choose_weight();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = 16'hFFFF;
            2:       v = WEIGHT_ONE;
            default: v = 16'($urandom());
        endcase
        return v;
    endfunction

    initial
    begin : stimulus
        logic [1:0] red;
        int         ign;
        int         cc;
        logic       lastp;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: mean over weight one, ignore value -100.
        send_pixel(0, 24'sh7FFFFF, 1'b0);
        send_pixel(1023, 24'sh800000, 1'b0);
        send_pixel(-100, 24'sd1234, 1'b0);
        send_pixel(1024, 24'sd99, 1'b1);       // range error carried into the total
        send_pixel(-100, 24'sd5, 1'b1);        // mean over zero weight
        send_pixel(-5, 24'sd7, 1'b1);          // range error beats zero weight
        send_pixel(5, -24'sd65536, 1'b1);
        send_weight(0, 16'h0000);
        send_weight(1023, 16'hFFFF);
        send_weight(7, WEIGHT_ONE);
        send_weight(512, 16'h0001);

        wait_for_results(1'b1);
        set_config(RED_NONE, -32768, 1'b1, 1024);
        send_pixel(1023, 24'sh800000, 1'b0);
        send_pixel(1023, 24'sh7FFFFF, 1'b0);
        send_pixel(0, 24'sd12345, 1'b0);
        send_pixel(512, 24'sd8192, 1'b0);      // product sits exactly on a rounding tie
        send_pixel(-32768, 24'sd1, 1'b0);
        send_pixel(32767, 24'sd2, 1'b0);
        send_pixel(-1, 24'sd3, 1'b1);          // last mark means nothing per pixel

        wait_for_results(1'b1);
        set_config(RED_SUM_ALIAS, 32767, 1'b1, 1);
        send_pixel(0, 24'sd100, 1'b0);
        send_pixel(1, 24'sd50, 1'b0);
        send_pixel(32767, 24'sd9, 1'b1);       // ignored pixel still closes the set
        send_pixel(0, -24'sd3, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 3)
                0:       red = RED_NONE;
                1:       red = RED_MEAN;
                default: red = RED_SUM;
            endcase
            case (ph % 4)
                0:       cc = 1024;
                1:       cc = $urandom_range(2, 1023);
                2:       cc = 16;
                default: cc = 1;
            endcase
            case (ph % 5)
                0:       ign = -100;
                1:       ign = (ph % 2) ? any_written() : int'($urandom_range(0, cc - 1));
                2:       ign = -32768;
                3:       ign = 32767;
                default: ign = int'($urandom_range(0, 65535)) - 32768;
            endcase
            if ((ph % 2) && ign >= 0 && ign < cc && ign < TABLE_DEPTH && !written[ign])
                ign = -1;

            // Sets left open at the end of a phase carry over into the next setting.
            wait_for_results(1'b1);
            set_config(red, ign, 1'(ph % 2), cc);

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 4 && i == PHASE_ITEMS / 2)
                    wait_for_results(1'b0);
                if ($urandom_range(0, 99) < 15)
                    send_weight($urandom_range(0, TABLE_DEPTH - 1), choose_weight());
                else
                begin
                    if (cur_reduction == RED_NONE)
                        lastp = 1'($urandom_range(0, 1));
                    else
                        lastp = ($urandom_range(0, 5) == 0);
                    send_pixel(choose_target(), choose_logit(), lastp);
                end
            end
        end

        wait_for_results(1'b1);
        $display("Sent %0d items (%0d pixels, %0d weight writes) under %0d register settings",
                 items_sent, pixels_sent, weights_sent, settings_run);
        $display("Checked %0d per-pixel losses and %0d set totals",
                 pixel_results, set_totals);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/nllfr_pkg.sv
hw/rtl/nllfr_weight_mem.sv
hw/rtl/nllfr_div.sv
hw/rtl/nll_loss_forward_reduce_unit.sv
hw/rtl/nllfr_checker.sv
test/nll_loss_checker.sv
test/tb_nll_loss_forward_reduce_unit.sv
